FILE: rtl/lasd_pkg.sv
`timescale 1ns / 1ps
// lasd_pkg: shared constants and types for the arithmetic-chain tracker
// no dependencies; used by lasd_clear_ctrl and longest_arith_subseq_by_diff
package lasd_pkg;

  localparam int unsigned ValueBitsDef  = 14;
  localparam int unsigned LengthBitsDef = 16;

  // table sweep sequencer states
  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_CLEAR = 3'b010,
    ST_WAIT  = 3'b100
  } sweep_state_e;

  // sweep sequencer to datapath
  typedef struct packed {
    logic ready;
    logic wr_en;
  } clr_ctrl_t;

endpackage

FILE: rtl/lasd_ram.sv
`timescale 1ns / 1ps
// lasd_ram: generic single-write, single-read ram with registered read data
// no dependencies
module lasd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read-before-write on a shared address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/lasd_clear_ctrl.sv
`timescale 1ns / 1ps
// lasd_clear_ctrl: sequencer that sweeps zeros through the chain table
// depends on lasd_pkg
module lasd_clear_ctrl #(
  parameter int unsigned AddrBits = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,    // last beat accepted
  input  logic                     hold_i,     // datapath owns the write port
  input  logic                     out_busy_i, // result slot still full next cycle
  output lasd_pkg::clr_ctrl_t      ctrl_o,
  output logic [AddrBits-1:0]      addr_o
);

  lasd_pkg::sweep_state_e state_q, state_d;
  logic [AddrBits-1:0]    cnt_q, cnt_d;
  logic                   wr_en;

  assign wr_en = (state_q == lasd_pkg::ST_CLEAR) && !hold_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      lasd_pkg::ST_RUN: begin
        if (start_i) begin
          state_d = lasd_pkg::ST_CLEAR;
          cnt_d   = '0;
        end
      end
      lasd_pkg::ST_CLEAR: begin
        if (wr_en) begin
          cnt_d = cnt_q + AddrBits'(1);
          if (&cnt_q) begin
            state_d = out_busy_i ? lasd_pkg::ST_WAIT : lasd_pkg::ST_RUN;
          end
        end
      end
      lasd_pkg::ST_WAIT: begin
        if (!out_busy_i) begin
          state_d = lasd_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = lasd_pkg::ST_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lasd_pkg::ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ctrl_o.ready = (state_q == lasd_pkg::ST_RUN);
  assign ctrl_o.wr_en = wr_en;
  assign addr_o       = cnt_q;

endmodule

FILE: rtl/longest_arith_subseq_by_diff.sv
`timescale 1ns / 1ps
// longest_arith_subseq_by_diff: streaming longest chain with a fixed step difference
// depends on lasd_pkg, lasd_ram, lasd_clear_ctrl
//
//   channel          direction  handshake                  payload
//   input            in         in_valid_i / in_stall_o    value_i, last_i
//   result           out        out_valid_o / out_stall_i  best_length_o
//   step_difference  in         step_difference_we_i       step_difference_i
//
// one beat per cycle while in_stall_o is low; the table ram (one read, one write port)
// sets that figure: read at acceptance, add and write back in the next cycle
// a result is loaded into the output register after its last beat has passed stage 1
// after reset and after every last beat all 2**VALUE_BITS table entries are swept to
// zero, one a cycle unless a datapath write holds the port; in_stall_o stays high meanwhile
// in_stall_o also stays high past the sweep while an earlier result is unclaimed
module longest_arith_subseq_by_diff #(
  parameter int unsigned VALUE_BITS  = lasd_pkg::ValueBitsDef,
  parameter int unsigned LENGTH_BITS = lasd_pkg::LengthBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   step_difference_we_i,
  input  logic [VALUE_BITS:0]    step_difference_i,
  // input beats
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_BITS-1:0]  value_i,
  input  logic                   last_i,
  // result beats
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LENGTH_BITS-1:0] best_length_o
);

  localparam int unsigned DiffBits = VALUE_BITS + 1;
  localparam int unsigned WideBits = VALUE_BITS + 2;
  localparam int unsigned Depth    = 2 ** VALUE_BITS;

  // step difference register
  logic [DiffBits-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (step_difference_we_i) begin
      step_q <= step_difference_i;
    end
  end

  // sweep sequencer
  lasd_pkg::clr_ctrl_t   clr;
  logic [VALUE_BITS-1:0] clr_addr;
  logic                  accept;
  logic                  s1_valid_q;
  logic                  out_valid_q;
  logic                  out_busy;

  assign accept     = in_valid_i && clr.ready;
  assign in_stall_o = !clr.ready;
  assign out_busy   = out_valid_q && out_stall_i;

  lasd_clear_ctrl #(
    .AddrBits (VALUE_BITS)
  ) u_clear_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && last_i),
    .hold_i     (s1_valid_q),
    .out_busy_i (out_busy),
    .ctrl_o     (clr),
    .addr_o     (clr_addr)
  );

  // stage 0: predecessor address, widened so it cannot wrap
  logic [WideBits-1:0]   prev_wide;
  logic                  prev_in_range;
  logic [VALUE_BITS-1:0] rd_addr;
  logic [VALUE_BITS-1:0] cur_idx;

  assign prev_wide = {{2{value_i[VALUE_BITS-1]}}, value_i}
                   - {step_q[DiffBits-1], step_q};
  // inside the signed table range when the top three bits agree
  assign prev_in_range = (prev_wide[WideBits-1] == prev_wide[WideBits-2])
                      && (prev_wide[WideBits-2] == prev_wide[VALUE_BITS-1]);
  // offset by half the table: flip the sign bit
  assign rd_addr = {~prev_wide[VALUE_BITS-1], prev_wide[VALUE_BITS-2:0]};
  assign cur_idx = {~value_i[VALUE_BITS-1], value_i[VALUE_BITS-2:0]};

  // stage 1 registers
  logic                   s1_last_q;
  logic                   s1_oor_q;
  logic [VALUE_BITS-1:0]  s1_idx_q;
  logic                   fwd_hit_q;
  logic [LENGTH_BITS-1:0] fwd_len_q;
  logic [LENGTH_BITS-1:0] rd_data;
  logic [LENGTH_BITS-1:0] pred_len;
  logic [LENGTH_BITS-1:0] s1_len;

  // the beat in stage 1 writes on the same edge the next beat reads, and the
  // ram returns the old word, so its length is forwarded one beat along
  assign pred_len = fwd_hit_q ? fwd_len_q : rd_data;

  always_comb begin
    if (s1_oor_q) begin
      s1_len = LENGTH_BITS'(1);
    end else if (&pred_len) begin
      s1_len = pred_len;              // saturated
    end else begin
      s1_len = pred_len + LENGTH_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= last_i;
      s1_oor_q  <= !prev_in_range;
      s1_idx_q  <= cur_idx;
      fwd_hit_q <= s1_valid_q && (rd_addr == s1_idx_q);
      fwd_len_q <= s1_len;
    end
  end

  // chain table: the datapath write wins, the sweep waits while it writes
  logic                   ram_we;
  logic [VALUE_BITS-1:0]  ram_waddr;
  logic [LENGTH_BITS-1:0] ram_wdata;

  assign ram_we    = s1_valid_q || clr.wr_en;
  assign ram_waddr = s1_valid_q ? s1_idx_q : clr_addr;
  assign ram_wdata = s1_valid_q ? s1_len : '0;

  lasd_ram #(
    .Width (LENGTH_BITS),
    .Depth (Depth)
  ) u_chain_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // running best, restarted with every sequence
  logic [LENGTH_BITS-1:0] best_q;
  logic [LENGTH_BITS-1:0] best_max;
  logic [LENGTH_BITS-1:0] out_best_q;

  assign best_max = (s1_len > best_q) ? s1_len : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else if (s1_valid_q) begin
      best_q <= s1_last_q ? '0 : best_max;
    end
  end

  // output register; the sweep keeps new beats out until it is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_last_q) begin
      out_best_q <= best_max;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_length_o = out_best_q;

  // a result only appears right after a last beat has passed stage 1
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without a last beat");

  // a new result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

  // sweep writes never collide with a datapath write
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && clr.wr_en))
    else $error("table write port conflict");

  // every sequence holds at least one element
  a_nonzero_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_length_o != '0))
    else $error("zero best length");

endmodule
